/* rtl/video_header_split_finder_core_assert.svh */
// Assertion macros for the header split finder.
// Used by the top level only; bodies are empty when SYNTHESIS is defined.
`ifndef VIDEO_HEADER_SPLIT_FINDER_CORE_ASSERT_SVH
`define VIDEO_HEADER_SPLIT_FINDER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define VHSF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vhsf assertion failed");
`define VHSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vhsf assertion failed");
`else
`define VHSF_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define VHSF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/vhsf_pkg.sv */
// Types and constants of the header split finder.
// No dependencies.
package vhsf_pkg;

    localparam logic [1:0] MODE_H264 = 2'd0;
    localparam logic [1:0] MODE_MPEG = 2'd1;

    localparam logic REG_CODEC_MODE = 1'b0;
    localparam logic REG_CHECK_ONLY = 1'b1;

    localparam logic [31:0] NAL_MASK   = 32'hFFFF_FF1F;
    localparam logic [31:0] SC_MASK    = 32'hFFFF_FF00;
    localparam logic [31:0] START_CODE = 32'h0000_0100;
    localparam logic [31:0] NAL_SPS    = 32'h0000_0107;
    localparam logic [31:0] NAL_PPS    = 32'h0000_0108;
    localparam logic [31:0] NAL_SLICE  = 32'h0000_0101;
    localparam logic [31:0] NAL_DPA    = 32'h0000_0102;
    localparam logic [31:0] NAL_IDR    = 32'h0000_0105;
    localparam logic [31:0] SEQ_HDR    = 32'h0000_01B3;
    localparam logic [31:0] EXT_CODE   = 32'h0000_01B5;
    localparam logic [31:0] SC_LIMIT   = 32'h0000_0200;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [15:0] split_offset;
        logic        compatible;
    } result_t;

    typedef struct packed {
        logic decided;
        logic at_start;
    } scan_status_t;

    typedef struct packed {
        logic        sps;
        logic        pps;
        logic        emit;
        logic [15:0] off;
        logic        comp;
    } nal_check_t;

endpackage

/* rtl/vhsf_in_stage.sv */
// Input request register of the header split finder.
// Depends on vhsf_pkg.
module vhsf_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  vhsf_pkg::item_t in_item,
    input  logic            advance,
    output logic            held_valid,
    output vhsf_pkg::item_t held_item
);

    logic            valid_reg;
    logic            valid_next;
    vhsf_pkg::item_t item_reg;
    logic            accept;

    assign in_stall   = valid_reg && !advance;
    assign accept     = in_valid && !in_stall;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

endmodule

/* rtl/vhsf_scan.sv */
// Start code scan state and split decision, one byte per step.
// Depends on vhsf_pkg.
module vhsf_scan
#(
    parameter int MAX_BUFFER_BYTES = 65536
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  vhsf_pkg::item_t        item,
    input  logic [1:0]             codec_mode,
    input  logic                   check_only,
    output logic                   res_valid,
    output vhsf_pkg::result_t      res,
    output vhsf_pkg::scan_status_t status
);

    localparam logic [15:0] POS_LIMIT =
        (MAX_BUFFER_BYTES - 1 > 65535) ? 16'hFFFF : 16'(MAX_BUFFER_BYTES - 1);

    logic [31:0] win_reg;
    logic [31:0] win_next;
    logic [15:0] pos_reg;
    logic [15:0] pos_next;
    logic [15:0] zrun_reg;
    logic [15:0] zrun_next;
    logic        sps_reg;
    logic        sps_next;
    logic        pps_reg;
    logic        pps_next;
    logic        seq_reg;
    logic        seq_next;
    logic        decided_reg;
    logic        decided_next;

    logic [31:0] w_sh;
    logic [15:0] z_sh;
    logic [15:0] p_sh;
    logic        sps1;
    logic        pps1;
    logic        first_one;
    vhsf_pkg::nal_check_t c1;
    vhsf_pkg::nal_check_t c2;
    logic        emit;
    logic [15:0] off;
    logic        comp;

    function automatic vhsf_pkg::nal_check_t h264_check(
        logic [31:0] w, logic [15:0] z, logic [15:0] p,
        logic sps, logic pps, logic chk);
        vhsf_pkg::nal_check_t r;
        logic [31:0] n;
        logic        slice;
        r = '0;
        n = w & vhsf_pkg::NAL_MASK;
        if (n == vhsf_pkg::NAL_SPS)
        begin
            r.sps = 1'b1;
        end
        if (n == vhsf_pkg::NAL_PPS)
        begin
            r.pps = 1'b1;
            if (chk)
            begin
                r.emit = 1'b1;
                r.comp = sps;
            end
        end
        slice = ((w & vhsf_pkg::SC_MASK) == vhsf_pkg::START_CODE) &&
                (n == vhsf_pkg::NAL_SLICE || n == vhsf_pkg::NAL_DPA ||
                 n == vhsf_pkg::NAL_IDR);
        if (slice && pps && !chk)
        begin
            r.emit = 1'b1;
            if (p >= 16'd4 && z <= p - 16'd4)
            begin
                r.off = p - 16'd4 - z;
            end
        end
        return r;
    endfunction

    assign w_sh = {win_reg[23:0], item.data_byte};
    assign z_sh = (win_reg[31:24] != 8'd0) ? 16'd0 :
                  (zrun_reg == 16'hFFFF) ? zrun_reg : zrun_reg + 16'd1;
    assign p_sh = (pos_reg < POS_LIMIT) ? pos_reg + 16'd1 : pos_reg;
    assign first_one = (pos_reg == 16'd0) && (item.data_byte == 8'd1);

    assign c1   = h264_check(win_reg, zrun_reg, pos_reg, sps_reg, pps_reg, check_only);
    assign sps1 = sps_reg | c1.sps;
    assign pps1 = pps_reg | c1.pps;
    assign c2   = h264_check(w_sh, z_sh, p_sh, sps1, pps1, check_only);

    always_comb
    begin
        win_next     = win_reg;
        pos_next     = pos_reg;
        zrun_next    = zrun_reg;
        sps_next     = sps_reg;
        pps_next     = pps_reg;
        seq_next     = seq_reg;
        decided_next = decided_reg;
        emit         = 1'b0;
        off          = 16'd0;
        comp         = 1'b0;

        if (step && !decided_reg)
        begin
            if (codec_mode != vhsf_pkg::MODE_H264 &&
                (check_only || codec_mode != vhsf_pkg::MODE_MPEG))
            begin
                emit = 1'b1;
                comp = check_only;
            end
            else if (codec_mode == vhsf_pkg::MODE_H264)
            begin
                if (check_only && first_one)
                begin
                    emit = 1'b1;
                    comp = 1'b1;
                end
                else
                begin
                    sps_next = sps1;
                    pps_next = pps1;
                    if (c1.emit)
                    begin
                        emit = 1'b1;
                        off  = c1.off;
                        comp = c1.comp;
                    end
                end
                if (!emit)
                begin
                    win_next  = w_sh;
                    zrun_next = z_sh;
                    pos_next  = p_sh;
                    if (item.last_byte)
                    begin
                        sps_next = sps1 | c2.sps;
                        pps_next = pps1 | c2.pps;
                        if (c2.emit)
                        begin
                            emit = 1'b1;
                            off  = c2.off;
                            comp = c2.comp;
                        end
                    end
                end
            end
            else
            begin
                win_next  = w_sh;
                zrun_next = z_sh;
                pos_next  = p_sh;
                if (w_sh == vhsf_pkg::SEQ_HDR)
                begin
                    seq_next = 1'b1;
                end
                else if (seq_reg && w_sh != vhsf_pkg::EXT_CODE &&
                         w_sh >= vhsf_pkg::START_CODE && w_sh < vhsf_pkg::SC_LIMIT)
                begin
                    emit = 1'b1;
                    off  = (pos_reg >= 16'd3) ? pos_reg - 16'd3 : 16'd0;
                end
            end
            if (!emit && item.last_byte)
            begin
                emit = 1'b1;
                off  = 16'd0;
                comp = 1'b0;
            end
            if (emit)
            begin
                decided_next = 1'b1;
            end
        end

        // end of buffer: clear for the next one
        if (step && item.last_byte)
        begin
            win_next     = '1;
            pos_next     = 16'd0;
            zrun_next    = 16'd0;
            sps_next     = 1'b0;
            pps_next     = 1'b0;
            seq_next     = 1'b0;
            decided_next = 1'b0;
        end
    end

    assign res_valid           = emit;
    assign res.split_offset    = off;
    assign res.compatible      = comp;
    assign status.decided      = decided_reg;
    assign status.at_start     = (pos_reg == 16'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg     <= '1;
            pos_reg     <= 16'd0;
            zrun_reg    <= 16'd0;
            sps_reg     <= 1'b0;
            pps_reg     <= 1'b0;
            seq_reg     <= 1'b0;
            decided_reg <= 1'b0;
        end
        else
        begin
            win_reg     <= win_next;
            pos_reg     <= pos_next;
            zrun_reg    <= zrun_next;
            sps_reg     <= sps_next;
            pps_reg     <= pps_next;
            seq_reg     <= seq_next;
            decided_reg <= decided_next;
        end
    end

endmodule

/* rtl/vhsf_out_stage.sv */
// Result register of the header split finder.
// Depends on vhsf_pkg.
module vhsf_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  vhsf_pkg::result_t res,
    output logic              out_valid,
    input  logic              out_stall,
    output vhsf_pkg::result_t out_res
);

    logic              valid_reg;
    logic              valid_next;
    vhsf_pkg::result_t res_reg;

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg && out_stall;
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

/* rtl/video_header_split_finder_core.sv */
// Top level of the header split finder: input register, scan, result register.
// Depends on vhsf_pkg, vhsf_in_stage, vhsf_scan, vhsf_out_stage and the assert header.
//
// Takes one byte per cycle, sustained, and gives one result per buffer. A byte is
// held in the input register, then the scan state (32-bit window, position, zero run,
// unit flags) is updated and any result goes to the result register, so a result
// passes the input register and then the result register before it is on the outputs.
// The scan state update loop sets the rate; the input stalls only while a result
// waits in the result register under out_stall. Bytes after the decision are absorbed
// until last_byte, which clears the scan state for the next buffer. Configuration may
// be written only while no buffer is in progress.
`include "video_header_split_finder_core_assert.svh"

module video_header_split_finder_core
#(
    parameter int MAX_BUFFER_BYTES = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] split_offset,
    output logic        compatible
);

    logic [1:0]             codec_mode_reg;
    logic                   check_only_reg;
    vhsf_pkg::item_t        in_item;
    vhsf_pkg::item_t        held_item;
    logic                   held_valid;
    logic                   advance;
    logic                   res_valid;
    vhsf_pkg::result_t      res;
    vhsf_pkg::result_t      out_res;
    vhsf_pkg::scan_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_mode_reg <= vhsf_pkg::MODE_H264;
            check_only_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vhsf_pkg::REG_CODEC_MODE: codec_mode_reg <= cfg_data;
                vhsf_pkg::REG_CHECK_ONLY: check_only_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign in_item.data_byte = data_byte;
    assign in_item.last_byte = last_byte;
    assign advance = held_valid && (!out_valid || !out_stall);

    vhsf_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    vhsf_scan #(.MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)) u_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .item       (held_item),
        .codec_mode (codec_mode_reg),
        .check_only (check_only_reg),
        .res_valid  (res_valid),
        .res        (res),
        .status     (status)
    );

    vhsf_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign split_offset = out_res.split_offset;
    assign compatible   = out_res.compatible;

    `VHSF_ASSERT_SAME(a_res_on_step, clk, rst_n, res_valid, advance)
    `VHSF_ASSERT_SAME(a_one_per_buffer, clk, rst_n, status.decided, !res_valid)
    `VHSF_ASSERT_NEXT(a_clear_on_last, clk, rst_n, advance && held_item.last_byte,
        status.at_start && !status.decided)
    `VHSF_ASSERT_SAME(a_stall_only_held, clk, rst_n, in_stall, held_valid)

endmodule

/* tb/tb_video_header_split_finder_core.sv */
// Testbench for video_header_split_finder_core: buffer scans in every codec and check setting.
// An internal scan predictor checks results; needs vhsf_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_video_header_split_finder_core;

    localparam int MAX_BUFFER_BYTES = 65536;
    localparam int POS_CAP = (MAX_BUFFER_BYTES - 1 > 65535) ? 65535 : MAX_BUFFER_BYTES - 1;
    localparam logic [1:0] MODE_NONE    = 2'd2;
    localparam logic [1:0] MODE_NONE_HI = 2'd3;
    localparam int RANDOM_ITEMS = 1600;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT  = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [1:0]  cfg_data = 2'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] split_offset;
    logic        compatible;

    video_header_split_finder_core #(
        .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .split_offset(split_offset),
        .compatible(compatible)
    );

    always #1 clk = ~clk;

    // scan predictor state
    logic [1:0]  mode_q = vhsf_pkg::MODE_H264;
    logic        check_q = 1'b0;
    logic [31:0] window = 32'hFFFF_FFFF;
    logic [15:0] position = '0;
    logic [15:0] zero_run = '0;
    logic        seen_sps = 1'b0;
    logic        seen_pps = 1'b0;
    logic        seen_seq = 1'b0;
    logic        decided = 1'b0;
    logic        first_one = 1'b0;

    vhsf_pkg::result_t expected_splits[$];
    logic [7:0] frame_bytes[$];
    int         mismatches = 0;
    int         idle_max = 10;
    int         quiet_cycles = 0;
    int         hold_left = 0;
    int         results_taken = 0;
    int         results_planned = 0;

    function automatic void expect_result(input logic [15:0] off, input logic comp);
        vhsf_pkg::result_t r;
        r.split_offset = off;
        r.compatible = comp;
        expected_splits.push_back(r);
        decided = 1'b1;
    endfunction

    function automatic void clear_scan();
        window = 32'hFFFF_FFFF;
        position = '0;
        zero_run = '0;
        seen_sps = 1'b0;
        seen_pps = 1'b0;
        seen_seq = 1'b0;
        decided = 1'b0;
        first_one = 1'b0;
    endfunction

    function automatic void check_nal(input logic [15:0] at);
        logic [31:0] nal;
        logic [15:0] off;
        nal = window & vhsf_pkg::NAL_MASK;
        off = '0;
        if (nal == vhsf_pkg::NAL_SPS)
            seen_sps = 1'b1;
        if (nal == vhsf_pkg::NAL_PPS)
        begin
            seen_pps = 1'b1;
            if (check_q)
                expect_result(16'd0, seen_sps);
        end
        if ((window & vhsf_pkg::SC_MASK) == vhsf_pkg::START_CODE && seen_pps && !check_q &&
            (nal == vhsf_pkg::NAL_SLICE || nal == vhsf_pkg::NAL_DPA ||
             nal == vhsf_pkg::NAL_IDR))
        begin
            if (at >= 16'd4 && zero_run <= at - 16'd4)
                off = at - 16'd4 - zero_run;
            expect_result(off, 1'b0);
        end
    endfunction

    function automatic void shift_byte(input logic [7:0] value);
        if (window[31:24] == 8'h00)
        begin
            if (zero_run != 16'hFFFF)
                zero_run = zero_run + 16'd1;
        end
        else
            zero_run = '0;
        window = {window[23:0], value};
        if (position < POS_CAP)
            position = position + 16'd1;
    endfunction

    function automatic void predict_split(input logic [7:0] value, input logic last);
        logic [15:0] at;
        at = position;
        if (!decided)
        begin
            if (at == 16'd0 && value == 8'h01)
                first_one = 1'b1;
            if (mode_q != vhsf_pkg::MODE_H264 && (check_q || mode_q != vhsf_pkg::MODE_MPEG))
                expect_result(16'd0, check_q);
            else if (mode_q == vhsf_pkg::MODE_H264)
            begin
                if (check_q && at == 16'd0 && first_one)
                    expect_result(16'd0, 1'b1);
                else
                    check_nal(at);
                if (!decided)
                begin
                    shift_byte(value);
                    if (last)
                        check_nal(position);
                end
            end
            else
            begin
                shift_byte(value);
                if (window == vhsf_pkg::SEQ_HDR)
                    seen_seq = 1'b1;
                else if (seen_seq && window != vhsf_pkg::EXT_CODE &&
                         window >= vhsf_pkg::START_CODE && window < vhsf_pkg::SC_LIMIT)
                    expect_result((at >= 16'd3) ? at - 16'd3 : 16'd0, 1'b0);
            end
            if (!decided && last)
                expect_result(16'd0, 1'b0);
        end
        if (last)
            clear_scan();
    endfunction

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", msg);
    endtask

    always @(posedge clk)
    begin : check_results
        vhsf_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_taken = results_taken + 1;
            if (expected_splits.size() == 0)
                note_failure($sformatf("unexpected result offset %0d compatible %0b",
                                       split_offset, compatible));
            else
            begin
                want = expected_splits.pop_front();
                if (split_offset !== want.split_offset)
                    note_failure($sformatf("split_offset expected %0d got %0d",
                                           want.split_offset, split_offset));
                if (compatible !== want.compatible)
                    note_failure($sformatf("compatible expected %0b got %0b",
                                           want.compatible, compatible));
            end
        end
    end

    // one wait drawn for each result request
    always @(negedge clk)
    begin
        if (out_valid && results_planned == results_taken)
        begin
            results_planned = results_planned + 1;
            hold_left = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        data_byte <= value;
        last_byte <= last;
        do
            @(posedge clk);
        while (in_stall);
        predict_split(value, last);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_splits.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        if (idx == vhsf_pkg::REG_CODEC_MODE)
            mode_q = value;
        else
            check_q = value[0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(input logic [1:0] mode, input logic chk);
        drain();
        write_reg(vhsf_pkg::REG_CODEC_MODE, mode);
        write_reg(vhsf_pkg::REG_CHECK_ONLY, {1'b0, chk});
    endtask

    task automatic push_start(input logic [7:0] code);
        repeat ($urandom_range(2, 4)) frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h01);
        frame_bytes.push_back(code);
    endtask

    function automatic logic [7:0] pick_code();
        logic [2:0] top;
        top = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 8))
            0: return {top, vhsf_pkg::NAL_SPS[4:0]};
            1: return {top, vhsf_pkg::NAL_PPS[4:0]};
            2: return {top, vhsf_pkg::NAL_SLICE[4:0]};
            3: return {top, vhsf_pkg::NAL_DPA[4:0]};
            4: return {top, vhsf_pkg::NAL_IDR[4:0]};
            5: return vhsf_pkg::SEQ_HDR[7:0];
            6: return vhsf_pkg::EXT_CODE[7:0];
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic build_frame();
        logic [2:0] top;
        frame_bytes.delete();
        top = 3'($urandom_range(0, 7));
        // mostly well-formed headers so the scan gets past its first states
        if ($urandom_range(0, 2) != 0)
        begin
            if (mode_q == vhsf_pkg::MODE_MPEG)
                push_start(vhsf_pkg::SEQ_HDR[7:0]);
            else
            begin
                push_start({top, vhsf_pkg::NAL_SPS[4:0]});
                repeat ($urandom_range(0, 4))
                    frame_bytes.push_back(8'($urandom_range(1, 255)));
                push_start({top, vhsf_pkg::NAL_PPS[4:0]});
            end
        end
        repeat ($urandom_range(1, 8))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: push_start(pick_code());
                5, 6: repeat ($urandom_range(1, 6))
                    frame_bytes.push_back(8'($urandom_range(1, 255)));
                7: repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'h00);
                8: frame_bytes.push_back(8'($urandom_range(0, 255)));
                default: frame_bytes.push_back(8'h01);
            endcase
        end
    endtask

    task automatic test_h264_split();
        apply_settings(vhsf_pkg::MODE_H264, 1'b0);
        frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h01, 8'h68,
                        8'h00, 8'h00, 8'h01, 8'h65};
        send_frame();
        frame_bytes = '{8'hFF};
        send_frame();
    endtask

    task automatic test_h264_check();
        apply_settings(vhsf_pkg::MODE_H264, 1'b1);
        frame_bytes = '{8'h01, 8'hFF};
        send_frame();
        frame_bytes = '{8'h00, 8'h00, 8'h01, 8'h68};
        send_frame();
        frame_bytes = '{8'hFF};
        send_frame();
    endtask

    task automatic test_mpeg();
        apply_settings(vhsf_pkg::MODE_MPEG, 1'b0);
        frame_bytes = '{8'h00, 8'h00, 8'h01, 8'hB3, 8'h00, 8'h00, 8'h01, 8'hB5,
                        8'h00, 8'h00, 8'h01, 8'h00, 8'h47};
        send_frame();
        apply_settings(vhsf_pkg::MODE_MPEG, 1'b1);
        frame_bytes = '{8'h80};
        send_frame();
    endtask

    task automatic test_unsupported();
        apply_settings(MODE_NONE, 1'b0);
        frame_bytes = '{8'hFF, 8'h00};
        send_frame();
        apply_settings(MODE_NONE, 1'b1);
        frame_bytes = '{8'h01};
        send_frame();
        apply_settings(MODE_NONE_HI, 1'b0);
        frame_bytes = '{8'h00};
        send_frame();
    endtask

    task automatic test_random_buffers();
        int sent;
        logic [1:0] mode;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent == 0 || $urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: mode = vhsf_pkg::MODE_H264;
                    5, 6, 7: mode = vhsf_pkg::MODE_MPEG;
                    8: mode = MODE_NONE;
                    default: mode = MODE_NONE_HI;
                endcase
                apply_settings(mode, $urandom_range(0, 3) == 0);
            end
            case ($urandom_range(0, 2))
                0: idle_max = 0;
                1: idle_max = 3;
                default: idle_max = 10;
            endcase
            build_frame();
            send_frame();
            sent += frame_bytes.size();
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        test_h264_split();
        test_h264_check();
        test_mpeg();
        test_unsupported();
        test_random_buffers();
        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
